// ===== src/tsd_pkg.sv =====
package tsd_pkg;

	localparam int RANK_BITS_DEF = 32;
	localparam int NUM_FIELDS    = 5;

	// Stage codes of an incoming request.
	localparam logic [1:0] STAGE_BASE    = 2'd0;
	localparam logic [1:0] STAGE_COEF    = 2'd1;
	localparam logic [1:0] STAGE_FINAL   = 2'd2;
	localparam logic [1:0] STAGE_INVALID = 2'd3;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// Field positions in the fold order.
	localparam int FIELD_SEED  = 0;
	localparam int FIELD_RUN   = 1;
	localparam int FIELD_STAGE = 2;
	localparam int FIELD_RANK  = 3;
	localparam int FIELD_GRANK = 4;

	localparam logic [63:0] FIELD_TAG [NUM_FIELDS] = '{
		64'h4241534553454544, 64'h52554e494e444558, 64'h5354414745544147,
		64'h574f524c4452414e, 64'h53504c495452414e
	};

	localparam logic [63:0] STAGE_WORD_BASE  = 64'h5036424153453032;
	localparam logic [63:0] STAGE_WORD_COEF  = 64'h5036434f45464632;
	localparam logic [63:0] STAGE_WORD_FINAL = 64'h503646494e414c32;

	localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

	typedef struct packed {
		logic [63:0] base_seed;
		logic [63:0] run_number;
		logic [1:0]  stage_code;
		logic [31:0] worker_rank;
		logic [31:0] worker_count;
		logic [31:0] group_size;
	} req_t;

	typedef struct packed {
		logic        result_status;
		logic [63:0] seed_out;
		logic [63:0] stage_word;
		logic [31:0] group_rank;
	} rsp_t;

	// Context that travels with a request down the pipeline.
	typedef struct packed {
		logic        err;
		logic [63:0] seed;
		logic [63:0] run;
		logic [1:0]  stage;
		logic [31:0] rank;
		logic [31:0] grank;
	} ctx_t;

	function automatic logic [63:0] stage_word(input logic [1:0] code);
		logic [63:0] w;
		case (code)
			STAGE_BASE:  w = STAGE_WORD_BASE;
			STAGE_COEF:  w = STAGE_WORD_COEF;
			STAGE_FINAL: w = STAGE_WORD_FINAL;
			default:     w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
		return 64'(a) * 64'(b);
	endfunction

endpackage

// ===== src/tsd_mod_cell.sv =====
module tsd_mod_cell #(
	parameter int WIDTH = tsd_pkg::RANK_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_i,
	input  logic [WIDTH-1:0] rem_i,
	input  logic [WIDTH-1:0] div_i,
	input  logic             num_bit,
	input  tsd_pkg::ctx_t    ctx_i,
	output logic             v_o,
	output logic [WIDTH-1:0] rem_o,
	output logic [WIDTH-1:0] div_o,
	output tsd_pkg::ctx_t    ctx_o
);
	import tsd_pkg::*;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] rem_n;
	logic             v_s1;
	logic [WIDTH-1:0] rem_s1;
	logic [WIDTH-1:0] div_s1;
	ctx_t             ctx_s1;

	// One restoring step: bring in the next dividend bit and subtract when it fits.
	always_comb begin
		trial = {rem_i, num_bit};
		diff  = trial - {1'b0, div_i};
		rem_n = (trial >= {1'b0, div_i}) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem_n;
			div_s1 <= div_i;
			ctx_s1 <= ctx_i;
		end
	end

	assign v_o   = v_s1;
	assign rem_o = rem_s1;
	assign div_o = div_s1;
	assign ctx_o = ctx_s1;

endmodule

// ===== src/tsd_mix.sv =====
module tsd_mix #(
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_i,
	input  logic [63:0]     x_i,
	input  logic [SB_W-1:0] sb_i,
	output logic            v_o,
	output logic [63:0]     x_o,
	output logic [SB_W-1:0] sb_o
);
	import tsd_pkg::*;

	logic [63:0]     a;
	logic [63:0]     p1;
	logic [63:0]     p2;
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [63:0]     y_s1;
	logic [63:0]     ll_s2;
	logic [31:0]     lh_s2, hl_s2;
	logic [63:0]     z_s3;
	logic [63:0]     ll_s4;
	logic [31:0]     lh_s4, hl_s4;
	logic [63:0]     w_s5;
	logic [SB_W-1:0] sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;

	// Each 64-bit product modulo 2^64 is built from three 32x32 partial products.
	always_comb begin
		a  = x_i + MIX_ADD;
		p1 = ll_s2 + {lh_s2 + hl_s2, 32'b0};
		p2 = ll_s4 + {lh_s4 + hl_s4, 32'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1  <= a ^ (a >> 30);
			sb_s1 <= sb_i;
			ll_s2 <= mul32(y_s1[31:0], MIX_MUL1[31:0]);
			lh_s2 <= y_s1[31:0] * MIX_MUL1[63:32];
			hl_s2 <= y_s1[63:32] * MIX_MUL1[31:0];
			sb_s2 <= sb_s1;
			z_s3  <= p1 ^ (p1 >> 27);
			sb_s3 <= sb_s2;
			ll_s4 <= mul32(z_s3[31:0], MIX_MUL2[31:0]);
			lh_s4 <= z_s3[31:0] * MIX_MUL2[63:32];
			hl_s4 <= z_s3[63:32] * MIX_MUL2[31:0];
			sb_s4 <= sb_s3;
			w_s5  <= p2 ^ (p2 >> 31);
			sb_s5 <= sb_s4;
		end
	end

	assign v_o  = v_s5;
	assign x_o  = w_s5;
	assign sb_o = sb_s5;

endmodule

// ===== src/tsd_fold_cell.sv =====
module tsd_fold_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [63:0]   hash_i,
	input  tsd_pkg::ctx_t ctx_i,
	output logic          v_o,
	output logic [63:0]   hash_o,
	output tsd_pkg::ctx_t ctx_o
);
	import tsd_pkg::*;

	localparam int CTX_W = $bits(ctx_t);

	logic [63:0]       field;
	logic              in_v;
	logic [63:0]       in_x;
	logic [CTX_W+63:0] in_sb;
	logic [CTX_W-1:0]  out_sb;

	always_comb begin
		case (IDX)
			FIELD_SEED:  field = ctx_i.seed;
			FIELD_RUN:   field = ctx_i.run;
			FIELD_STAGE: field = stage_word(ctx_i.stage);
			FIELD_RANK:  field = {32'b0, ctx_i.rank};
			FIELD_GRANK: field = {32'b0, ctx_i.grank};
			default:     field = '0;
		endcase
	end

	// The tagged field is mixed while the running hash rides along beside it.
	tsd_mix #(.SB_W(CTX_W + 64)) u_inner (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_i),
		.x_i    (field ^ FIELD_TAG[IDX]),
		.sb_i   ({ctx_i, hash_i}),
		.v_o    (in_v),
		.x_o    (in_x),
		.sb_o   (in_sb)
	);

	tsd_mix #(.SB_W(CTX_W)) u_outer (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (in_v),
		.x_i    (in_sb[63:0] ^ in_x),
		.sb_i   (in_sb[CTX_W+63:64]),
		.v_o    (v_o),
		.x_o    (hash_o),
		.sb_o   (out_sb)
	);

	assign ctx_o = out_sb;

endmodule

// ===== src/tagged_splitmix_seed_derive_unit.sv =====
// Derives a 64-bit seed from a base seed, a run index, a stage code and a worker
// rank by folding five tagged fields through splitmix64 steps, starting from the
// initial_domain register. Requests that fail the argument check (stage code 3,
// zero worker count or group size, rank not below count) come back with status 1
// and all other fields zero. One transaction is accepted per clock; each passes
// on its way to the output through one input register, one remainder cell per
// rank bit (RANK_W cells, RANK_BITS capped at 32), ten stages in each of the
// five fold cells and five in the closing mix, and one output register. A skid
// register behind the output absorbs one result when the receiver stalls; the
// request side stalls only while that skid register is full. Write initial_domain
// only while no transaction is in flight.
module tagged_splitmix_seed_derive_unit #(
	parameter int RANK_BITS = tsd_pkg::RANK_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [63:0]   cfg_wr_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  tsd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tsd_pkg::rsp_t rsp
);
	import tsd_pkg::*;

	localparam int          RANK_W    = (RANK_BITS < 32) ? RANK_BITS : 32;
	localparam logic [32:0] MASK_WIDE = (33'd1 << RANK_W) - 33'd1;
	localparam logic [31:0] RANK_MASK = MASK_WIDE[31:0];

	logic        en;
	logic [63:0] initial_domain_q;

	logic [31:0] rank_m, count_m, gsize_m;
	ctx_t        ctx_n;

	logic              v_s1;
	ctx_t              ctx_s1;
	logic [RANK_W-1:0] div_s1;

	logic              m_v   [RANK_W+1];
	logic [RANK_W-1:0] m_rem [RANK_W+1];
	logic [RANK_W-1:0] m_div [RANK_W+1];
	ctx_t              m_ctx [RANK_W+1];
	ctx_t              mod_ctx;

	logic        f_v    [NUM_FIELDS+1];
	logic [63:0] f_hash [NUM_FIELDS+1];
	ctx_t        f_ctx  [NUM_FIELDS+1];

	logic        fin_v;
	logic [63:0] fin_x;
	ctx_t        fin_ctx;
	rsp_t        res;

	logic        out_valid_q;
	rsp_t        out_q;
	logic        skid_valid_q;
	rsp_t        skid_q;

	// The whole pipeline advances together; only a full skid register holds it.
	assign en        = !skid_valid_q;
	assign req_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_domain_q <= '0;
		end else if (cfg_wr_en) begin
			initial_domain_q <= cfg_wr_data;
		end
	end

	always_comb begin
		rank_m  = req.worker_rank & RANK_MASK;
		count_m = req.worker_count & RANK_MASK;
		gsize_m = req.group_size & RANK_MASK;
		ctx_n.err = (req.stage_code == STAGE_INVALID) || (count_m == '0) ||
			(gsize_m == '0) || (rank_m >= count_m);
		ctx_n.seed  = req.base_seed;
		ctx_n.run   = req.run_number;
		ctx_n.stage = req.stage_code;
		ctx_n.rank  = rank_m;
		ctx_n.grank = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_n;
			div_s1 <= gsize_m[RANK_W-1:0];
		end
	end

	assign m_v[0]   = v_s1;
	assign m_rem[0] = '0;
	assign m_div[0] = div_s1;
	assign m_ctx[0] = ctx_s1;

	// Remainder of rank by group size, one dividend bit per cell, top bit first.
	for (genvar k = 0; k < RANK_W; k++) begin : g_mod
		tsd_mod_cell #(.WIDTH(RANK_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_i     (m_v[k]),
			.rem_i   (m_rem[k]),
			.div_i   (m_div[k]),
			.num_bit (m_ctx[k].rank[RANK_W-1-k]),
			.ctx_i   (m_ctx[k]),
			.v_o     (m_v[k+1]),
			.rem_o   (m_rem[k+1]),
			.div_o   (m_div[k+1]),
			.ctx_o   (m_ctx[k+1])
		);
	end

	always_comb begin
		mod_ctx       = m_ctx[RANK_W];
		mod_ctx.grank = 32'(m_rem[RANK_W]);
	end
	assign f_ctx[0]  = mod_ctx;
	assign f_v[0]    = m_v[RANK_W];
	assign f_hash[0] = initial_domain_q;

	for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_fold
		tsd_fold_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (f_v[i]),
			.hash_i (f_hash[i]),
			.ctx_i  (f_ctx[i]),
			.v_o    (f_v[i+1]),
			.hash_o (f_hash[i+1]),
			.ctx_o  (f_ctx[i+1])
		);
	end

	tsd_mix #(.SB_W($bits(ctx_t))) u_final (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (f_v[NUM_FIELDS]),
		.x_i    (f_hash[NUM_FIELDS]),
		.sb_i   (f_ctx[NUM_FIELDS]),
		.v_o    (fin_v),
		.x_o    (fin_x),
		.sb_o   (fin_ctx)
	);

	always_comb begin
		if (fin_ctx.err) begin
			res.result_status = STATUS_INVALID;
			res.seed_out      = '0;
			res.stage_word    = '0;
			res.group_rank    = '0;
		end else begin
			res.result_status = STATUS_OK;
			res.seed_out      = fin_x;
			res.stage_word    = stage_word(fin_ctx.stage);
			res.group_rank    = fin_ctx.grank;
		end
	end

	// A result arriving while the output register waits goes to the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!rsp_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && rsp_stall) begin
			skid_valid_q <= fin_v;
		end else begin
			out_valid_q <= fin_v;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!rsp_stall) begin
				out_q <= skid_q;
			end
		end else if (out_valid_q && rsp_stall) begin
			skid_q <= res;
		end else begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
